// ===== hw/rtl/range_bearing_to_global_point_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RANGE_BEARING_TO_GLOBAL_POINT_MACROS_SVH
`define RANGE_BEARING_TO_GLOBAL_POINT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RBG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RBG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/rbg_pkg.sv =====
// Package: payload types, constants and the CORDIC arctangent table.
package rbg_pkg;
  localparam int CordicStagesDef = 16;
  localparam int TableLen = 24;
  localparam logic [27:0] KinvQ28 = 28'd163008219;

  typedef struct packed {
    logic        [23:0] target_range;
    logic        [15:0] target_bearing;
    logic signed [31:0] platform_x;
    logic signed [31:0] platform_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } rbg_in_t;

  typedef struct packed {
    logic signed [31:0] global_x;
    logic signed [31:0] global_y;
    logic               overflowed;
  } rbg_out_t;

  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction
endpackage

// ===== hw/rtl/rbg_cordic_stage.sv =====
// One registered CORDIC micro-rotation, vectoring or rotating mode.
module rbg_cordic_stage
  import rbg_pkg::*;
#(
  parameter int IDX = 0,
  parameter bit VECTORING = 1'b1,
  parameter int W = 56,
  parameter int SW = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_i,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [33:0]   z_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [33:0]   z_o,
  output logic [SW-1:0]        side_o
);
  localparam logic [4:0] Idx = 5'(IDX);
  logic signed [W-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [33:0] z_nxt, at;
  logic dir;
  logic vld_r;
  logic signed [W-1:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [SW-1:0] side_r;

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    at = signed'({2'b00, atan_tab(Idx)});
    // vectoring: drive y to zero; rotating: drive z to zero
    dir = VECTORING ? !y_i[W-1] : !z_i[33];
    if (VECTORING) begin
      if (dir) begin
        x_nxt = x_i + ys; y_nxt = y_i - xs; z_nxt = z_i + at;
      end else begin
        x_nxt = x_i - ys; y_nxt = y_i + xs; z_nxt = z_i - at;
      end
    end else begin
      if (dir) begin
        x_nxt = x_i - ys; y_nxt = y_i + xs; z_nxt = z_i - at;
      end else begin
        x_nxt = x_i + ys; y_nxt = y_i - xs; z_nxt = z_i + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
    if (adv) begin
      x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; side_r <= side_i;
    end
  end
  assign vld_o = vld_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign side_o = side_r;
endmodule

// ===== hw/rtl/range_bearing_to_global_point.sv =====
// Top level: pipelined range/bearing to global point converter.
// Usage:
//   Input channel in_valid/in_stall/in_data carries one detection item:
//   range, bearing, platform position and orientation quaternion.
//   Output channel out_valid/out_stall/out_data carries the global point
//   and an overflow flag, one result item per input item, in order.
// Pipeline: input register, two quaternion product stages, vectoring
//   CORDIC, angle/setup stage, rotating CORDIC, output add/saturate
//   stage; the length of each CORDIC chain is CORDIC_STAGES capped
//   at 24.
// Throughput: one item per cycle while no stall holds the pipeline;
//   every stage is a register set; CORDIC chain length sets latency only.
// Stall: out_stall freezes the whole pipeline, bubbles included, and
//   in_stall follows out_stall while the output register holds a valid
//   item; with the output register empty the pipeline keeps advancing.
// Reset: rst_n (synchronous, low) clears every valid bit; payload
//   registers are not reset. No state is kept between items.
module range_bearing_to_global_point
  import rbg_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rbg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rbg_out_t out_data
);
  localparam int NS = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
  localparam int VW = 36;  // t3/t4 grow by CORDIC gain < 1.65
  localparam int RW = 56;  // range * KINV in Q.28, plus growth
  localparam int VSW = 16 + 24 + 64; // bearing, range, position
  localparam int RSW = 64;

  // Advance when the output slot is free or being taken.
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage A: register the input item
  logic a_vld_r;
  rbg_in_t a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_valid;
    if (adv) a_r <= in_data;
  end

  // Stage B: quaternion products
  logic b_vld_r;
  logic signed [31:0] b_wz_r, b_xy_r, b_yy_r, b_zz_r;
  logic [VSW-1:0] b_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (adv) b_vld_r <= a_vld_r;
    if (adv) begin
      b_wz_r <= a_r.quat_w * a_r.quat_z;
      b_xy_r <= a_r.quat_x * a_r.quat_y;
      b_yy_r <= a_r.quat_y * a_r.quat_y;
      b_zz_r <= a_r.quat_z * a_r.quat_z;
      b_side_r <= {a_r.target_bearing, a_r.target_range, a_r.platform_x, a_r.platform_y};
    end
  end

  // Stage C: t3, t4 and quadrant fold for the vectoring CORDIC
  logic signed [VW-1:0] t3, t4, c_x, c_y;
  logic signed [33:0] c_z;
  logic c_zero;
  always_comb begin
    t3 = (VW'(b_wz_r) + VW'(b_xy_r)) <<< 1;
    t4 = (VW'(36'sd1) <<< 30) - ((VW'(b_yy_r) + VW'(b_zz_r)) <<< 1);
    c_zero = (t3 == '0) && (t4 == '0);
    if (t4[VW-1]) begin
      c_x = -t4; c_y = -t3; c_z = 34'sh080000000;
    end else begin
      c_x = t4; c_y = t3; c_z = '0;
    end
  end
  logic c_vld_r;
  logic signed [VW-1:0] c_x_r, c_y_r;
  logic signed [33:0] c_z_r;
  logic [VSW:0] c_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (adv) c_vld_r <= b_vld_r;
    if (adv) begin
      c_x_r <= c_x; c_y_r <= c_y; c_z_r <= c_z;
      c_side_r <= {c_zero, b_side_r};
    end
  end

  // Vectoring CORDIC chain
  logic v_vld [NS+1];
  logic signed [VW-1:0] v_x [NS+1];
  logic signed [VW-1:0] v_y [NS+1];
  logic signed [33:0] v_z [NS+1];
  logic [VSW:0] v_side [NS+1];
  assign v_vld[0] = c_vld_r;
  assign v_x[0] = c_x_r;
  assign v_y[0] = c_y_r;
  assign v_z[0] = c_z_r;
  assign v_side[0] = c_side_r;
  for (genvar g = 0; g < NS; g++) begin : g_vec
    rbg_cordic_stage #(.IDX(g), .VECTORING(1'b1), .W(VW), .SW(VSW + 1)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_i(v_vld[g]), .x_i(v_x[g]), .y_i(v_y[g]), .z_i(v_z[g]), .side_i(v_side[g]),
      .vld_o(v_vld[g+1]), .x_o(v_x[g+1]), .y_o(v_y[g+1]), .z_o(v_z[g+1]),
      .side_o(v_side[g+1])
    );
  end

  // Stage D: yaw rounding, bearing add, quadrant fold, range * KINV
  logic [31:0] acc;
  logic [15:0] yaw16, theta, zt;
  logic [23:0] d_range;
  logic signed [RW-1:0] d_cx;
  logic signed [33:0] d_z;
  always_comb begin
    acc = v_side[NS][VSW] ? 32'h0 : v_z[NS][31:0];
    yaw16 = 16'((acc + 32'h8000) >> 16);
    theta = yaw16 + v_side[NS][VSW-1 -: 16];
    d_range = v_side[NS][VSW-17 -: 24];
    d_cx = RW'($signed({1'b0, d_range}) * $signed({1'b0, KinvQ28}));
    zt = theta;
    if (16'(theta + 16'h4000) >= 16'h8000) begin
      d_cx = -d_cx;
      zt = theta - 16'h8000;
    end
    d_z = {{2{zt[15]}}, zt, 16'h0};
  end
  logic d_vld_r;
  logic signed [RW-1:0] d_cx_r;
  logic signed [33:0] d_z_r;
  logic [63:0] d_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (adv) d_vld_r <= v_vld[NS];
    if (adv) begin
      d_cx_r <= d_cx; d_z_r <= d_z; d_side_r <= v_side[NS][63:0];
    end
  end

  // Rotating CORDIC chain
  logic r_vld [NS+1];
  logic signed [RW-1:0] r_x [NS+1];
  logic signed [RW-1:0] r_y [NS+1];
  logic signed [33:0] r_z [NS+1];
  logic [RSW-1:0] r_side [NS+1];
  assign r_vld[0] = d_vld_r;
  assign r_x[0] = d_cx_r;
  assign r_y[0] = '0;
  assign r_z[0] = d_z_r;
  assign r_side[0] = d_side_r;
  for (genvar g = 0; g < NS; g++) begin : g_rot
    rbg_cordic_stage #(.IDX(g), .VECTORING(1'b0), .W(RW), .SW(RSW)) u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_i(r_vld[g]), .x_i(r_x[g]), .y_i(r_y[g]), .z_i(r_z[g]), .side_i(r_side[g]),
      .vld_o(r_vld[g+1]), .x_o(r_x[g+1]), .y_o(r_y[g+1]), .z_o(r_z[g+1]),
      .side_o(r_side[g+1])
    );
  end

  // Output stage: round, add position, saturate
  logic signed [RW-1:0] rx, ry;
  logic signed [33:0] gx, gy;
  rbg_out_t o_nxt;
  logic ox, oy;
  always_comb begin
    rx = (r_x[NS] + (RW'(1) <<< 27)) >>> 28;
    ry = (r_y[NS] + (RW'(1) <<< 27)) >>> 28;
    // Sign-extend the rounded offsets; they can point either way.
    gx = 34'(signed'(r_side[NS][63:32])) + 34'(signed'(rx[RW-29:0]));
    gy = 34'(signed'(r_side[NS][31:0])) + 34'(signed'(ry[RW-29:0]));
    ox = (gx[33:31] != 3'b000) && (gx[33:31] != 3'b111);
    oy = (gy[33:31] != 3'b000) && (gy[33:31] != 3'b111);
    o_nxt.global_x = ox ? (gx[33] ? 32'sh80000000 : 32'sh7FFFFFFF) : gx[31:0];
    o_nxt.global_y = oy ? (gy[33] ? 32'sh80000000 : 32'sh7FFFFFFF) : gy[31:0];
    o_nxt.overflowed = ox || oy;
  end
  logic out_vld_r;
  rbg_out_t out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= r_vld[NS];
    if (adv) out_r <= o_nxt;
  end
  assign out_valid = out_vld_r;
  assign out_data = out_r;
endmodule

// ===== hw/rtl/rbg_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`include "range_bearing_to_global_point_macros.svh"
module rbg_checker
  import rbg_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input rbg_out_t out_data
);
  `RBG_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `RBG_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(out_data))
  `RBG_ASSERT_IMP(a_stall_back, in_stall, out_valid && out_stall)
  `RBG_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid)
  `RBG_ASSERT_IMP(a_sat_flag, out_valid && out_data.overflowed,
    (out_data.global_x == 32'sh7FFFFFFF) || (out_data.global_x == 32'sh80000000) ||
    (out_data.global_y == 32'sh7FFFFFFF) || (out_data.global_y == 32'sh80000000))
endmodule

bind range_bearing_to_global_point rbg_checker u_rbg_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== verif/range_bearing_to_global_point_test.sv =====
// Self-checking bench for the range/bearing to global point converter.
`timescale 1ns / 1ps

module range_bearing_to_global_point_test;
  import rbg_pkg::*;

  localparam int NumStages = 16;
  localparam int Latency = 2 * NumStages + 6;
  localparam int IdleLimit = 2000;
  localparam int NumRandom = 700;
  localparam int InBits = $bits(rbg_in_t);
  localparam logic signed [63:0] Kinv = 64'sd163008219;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rbg_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rbg_out_t out_data;

  rbg_in_t pending_items[$];
  rbg_out_t expected_points[$];
  logic stimulus_done = 1'b0;
  logic quiet_end = 1'b0;
  logic in_taken = 1'b0;
  int error_count = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_hold = 0;

  always #5 clk = ~clk;

  range_bearing_to_global_point #(.CORDIC_STAGES(NumStages)) dut (.*);

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic signed [63:0] arctan_step(input int i);
    logic [31:0] a[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return {32'b0, a[i]};
  endfunction

  // Compute the global point that one detection should produce.
  function automatic rbg_out_t locate_target(input rbg_in_t d);
    logic signed [63:0] qw, qx, qy, qz, sin_term, cos_term, xs, ys;
    logic signed [63:0] cx, cy, z, gx, gy;
    logic [31:0] heading;
    logic [15:0] yaw, theta;
    logic ovf;
    rbg_out_t r;
    qw = d.quat_w; qx = d.quat_x; qy = d.quat_y; qz = d.quat_z;
    sin_term = 2 * (qw * qz + qx * qy);
    cos_term = (64'sd1 <<< 30) - 2 * (qy * qy + qz * qz);
    heading = '0;
    // Degenerate quaternion: both terms zero gives zero yaw.
    if (sin_term != 0 || cos_term != 0) begin
      if (cos_term < 0) begin
        cos_term = -cos_term;
        sin_term = -sin_term;
        heading = 32'h80000000;
      end
      for (int i = 0; i < NumStages && i < 24; i++) begin
        xs = cos_term >>> i;
        ys = sin_term >>> i;
        if (sin_term >= 0) begin
          cos_term += ys;
          sin_term -= xs;
          heading += 32'(arctan_step(i));
        end else begin
          cos_term -= ys;
          sin_term += xs;
          heading -= 32'(arctan_step(i));
        end
      end
    end
    heading = heading + 32'h8000;
    yaw = heading[31:16];
    theta = yaw + d.target_bearing;
    cx = $signed({40'b0, d.target_range}) * Kinv;
    cy = 0;
    // Fold the back half-plane onto the front one.
    if (((theta + 16'h4000) & 16'h8000) != 0) begin
      cx = -cx;
      z = 64'($signed(16'(theta - 16'h8000))) * 65536;
    end else begin
      z = 64'($signed(theta)) * 65536;
    end
    for (int i = 0; i < NumStages && i < 24; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx -= ys;
        cy += xs;
        z -= arctan_step(i);
      end else begin
        cx += ys;
        cy -= xs;
        z += arctan_step(i);
      end
    end
    gx = 64'(d.platform_x) + ((cx + (64'sd1 <<< 27)) >>> 28);
    gy = 64'(d.platform_y) + ((cy + (64'sd1 <<< 27)) >>> 28);
    ovf = 1'b0;
    if (gx > 64'sd2147483647) begin ovf = 1'b1; gx = 64'sd2147483647; end
    if (gx < -64'sd2147483648) begin ovf = 1'b1; gx = -64'sd2147483648; end
    if (gy > 64'sd2147483647) begin ovf = 1'b1; gy = 64'sd2147483647; end
    if (gy < -64'sd2147483648) begin ovf = 1'b1; gy = -64'sd2147483648; end
    r.global_x = gx[31:0];
    r.global_y = gy[31:0];
    r.overflowed = ovf;
    return r;
  endfunction

  function automatic rbg_in_t random_item();
    rbg_in_t d;
    d = InBits'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    // Mostly small ranges and positions so overflow stays occasional.
    if ($urandom_range(0, 3) != 0) begin
      d.target_range = 24'($urandom_range(0, 100000));
      d.platform_x = 32'($signed($urandom_range(0, 2000000)) - 1000000);
      d.platform_y = 32'($signed($urandom_range(0, 2000000)) - 1000000);
    end
    // Sometimes aim near the rails to provoke saturation.
    if ($urandom_range(0, 9) == 0) begin
      d.platform_x = $urandom_range(0, 1) ? 32'sh7FFFF000 : 32'sh80000FFF;
      d.platform_y = $urandom_range(0, 1) ? 32'sh7FFFF000 : 32'sh80000FFF;
    end
    return d;
  endfunction

  function automatic rbg_in_t make_item(input logic [23:0] rng, input logic [15:0] brg,
      input logic [31:0] px, input logic [31:0] py, input logic [15:0] w,
      input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
    rbg_in_t d;
    d = {rng, brg, px, py, w, x, y, z};
    return d;
  endfunction

  // Fill the item queue: directed corners, then random detections.
  initial begin
    pending_items.push_back(make_item(24'd0, 16'd0, 32'd0, 32'd0, 16'h7FFF, 16'd0, 16'd0,
      16'd0));
    pending_items.push_back(make_item(24'hFFFFFF, 16'h0000, 32'd0, 32'd0, 16'h7FFF, 16'd0,
      16'd0, 16'd0));
    pending_items.push_back(make_item(24'hFFFFFF, 16'h4000, 32'd0, 32'd0, 16'h7FFF, 16'd0,
      16'd0, 16'd0));
    pending_items.push_back(make_item(24'hFFFFFF, 16'h8000, 32'd0, 32'd0, 16'h7FFF, 16'd0,
      16'd0, 16'd0));
    pending_items.push_back(make_item(24'hFFFFFF, 16'hC000, 32'd0, 32'd0, 16'h7FFF, 16'd0,
      16'd0, 16'd0));
    pending_items.push_back(make_item(24'hFFFFFF, 16'hFFFF, 32'd0, 32'd0, 16'h7FFF, 16'd0,
      16'd0, 16'd0));
    // Degenerate quaternion and extreme components.
    pending_items.push_back(make_item(24'd5000, 16'h1234, 32'd0, 32'd0, 16'd0, 16'd0,
      16'h5A82, 16'h5A82));
    pending_items.push_back(make_item(24'd5000, 16'h0100, 32'd0, 32'd0, 16'd0, 16'd0,
      16'd0, 16'd0));
    pending_items.push_back(make_item(24'd77777, 16'h2000, 32'd100, 32'd200, 16'h8000,
      16'h8000, 16'h8000, 16'h8000));
    pending_items.push_back(make_item(24'd77777, 16'h6000, 32'd0, 32'd0, 16'h7FFF,
      16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_items.push_back(make_item(24'd1000, 16'h0000, 32'd0, 32'd0, 16'd0, 16'd0,
      16'd0, 16'h7FFF));
    pending_items.push_back(make_item(24'd1000, 16'hE000, 32'd0, 32'd0, 16'd0, 16'd0,
      16'd0, 16'h8000));
    // Wrap of yaw plus bearing past one turn.
    pending_items.push_back(make_item(24'd3000, 16'hF000, 32'd0, 32'd0, 16'h5A82, 16'd0,
      16'd0, 16'h5A82));
    // Saturation at every rail.
    pending_items.push_back(make_item(24'hFFFFFF, 16'h0000, 32'h7FFFFFFF, 32'h7FFFFFFF,
      16'h7FFF, 16'd0, 16'd0, 16'd0));
    pending_items.push_back(make_item(24'hFFFFFF, 16'h8000, 32'h80000000, 32'h80000000,
      16'h7FFF, 16'd0, 16'd0, 16'd0));
    pending_items.push_back(make_item(24'hFFFFFF, 16'h4000, 32'h80000000, 32'h7FFFFFFF,
      16'h7FFF, 16'd0, 16'd0, 16'd0));
    pending_items.push_back(make_item(24'hFFFFFF, 16'hC000, 32'h7FFFFFFF, 32'h80000000,
      16'h7FFF, 16'd0, 16'd0, 16'd0));
    pending_items.push_back(make_item(24'hAAAAAA, 16'h5555, 32'h55555555, 32'hAAAAAAAA,
      16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    for (int n = 0; n < NumRandom; n++) pending_items.push_back(random_item());
  end

  // Hold reset at start, then release it.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // Driver: on acceptance predict the result and advance; gaps come in bursts.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        expected_points.push_back(locate_target(in_data));
        void'(pending_items.pop_front());
      end
      if (pending_items.size() < 60) quiet_end <= 1'b1;
      // Hold the item until it has been taken.
      if (!in_valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet_end && $urandom_range(0, 19) == 0) begin
          in_gap <= $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end else begin
          in_valid <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
      // Receiver stall bursts.
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
      end else if (!quiet_end && $urandom_range(0, 14) == 0) begin
        out_hold <= $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: note input acceptance and compare each result item with the
  // oldest expectation.
  always @(posedge clk) begin
    rbg_out_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (out_data.global_x !== want.global_x)
          $display("%0t: global_x expected %0d actual %0d", $time, want.global_x,
            out_data.global_x);
        if (out_data.global_y !== want.global_y)
          $display("%0t: global_y expected %0d actual %0d", $time, want.global_y,
            out_data.global_y);
        if (out_data.overflowed !== want.overflowed)
          $display("%0t: overflowed expected %0b actual %0b", $time, want.overflowed,
            out_data.overflowed);
        if (out_data !== want) error_count++;
      end
    end
  end

  // Watchdog: count cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // End: drain, let the pipeline settle, then report.
  initial begin
    wait (stimulus_done && expected_points.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
